FILE: hw/rtl/bbe_pkg.sv
// Shared constants, types and the reciprocal table for the 3x3 box blur.
`timescale 1ns / 1ps
package bbe_pkg;

  // Frame geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int FW_W      = 11;
  localparam int FH_W      = 16;
  localparam int TAKEN_W   = FW_W;

  // Configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [FW_W-1:0] FW_RESET = 11'd1024;
  localparam logic [FH_W-1:0] FH_RESET = 16'd768;

  // Request commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // Arithmetic widths
  localparam int CSUM_W      = 10;  // three 8-bit values
  localparam int TSUM_W      = 12;  // nine 8-bit values
  localparam int NUM_W       = 13;  // 2*sum + count
  localparam int CNT_W       = 4;   // neighbor count, 1..9
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 17;
  localparam int PROD_W      = NUM_W + RECIP_W;

  // Output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  // Window: index [row][col], row 0 on top, col 0 on the left
  typedef pix_t [2:0]     win_row_t;
  typedef win_row_t [2:0] win_t;

  typedef struct packed {
    logic emit;
    logic has_left;
    logic has_right;
    logic has_top;
    logic has_bottom;
    logic last;
  } ctrl_t;

  typedef struct packed {
    pix_t color;
    logic last;
  } res_t;

  // ceil(2^17 / (2*count)); exact floor for every numerator below 4600
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
    logic [RECIP_W-1:0] m;
    case (cnt)
      4'd1:    m = 17'd65536;
      4'd2:    m = 17'd32768;
      4'd3:    m = 17'd21846;
      4'd4:    m = 17'd16384;
      4'd6:    m = 17'd10923;
      4'd9:    m = 17'd7282;
      default: m = 17'd65536;
    endcase
    return m;
  endfunction

endpackage

FILE: hw/rtl/bbe_window.sv
// Line buffer memory with read-modify-write forwarding and the 3x3 window.
`timescale 1ns / 1ps
module bbe_window
  import bbe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             acc,
  input  logic [COL_W-1:0] col,
  input  pix_t             pix,
  input  ctrl_t            ctrl_in,
  output logic             win_valid,
  output win_t             win,
  output ctrl_t            win_ctrl
);

  // One entry per column: rows two and one above the input row
  typedef struct packed {
    pix_t older;
    pix_t prev;
  } line_ent_t;

  line_ent_t        line_mem [MAX_WIDTH];
  line_ent_t        rd_data_r;
  line_ent_t        fwd_data_r;
  line_ent_t        rd_ent;
  line_ent_t        wr_ent;
  logic             fwd_hit_r;
  logic             s1_valid_r;
  logic [COL_W-1:0] s1_col_r;
  pix_t             s1_pix_r;
  ctrl_t            s1_ctrl_r;
  logic             win_valid_r;
  win_t             win_r;
  ctrl_t            win_ctrl_r;

  // Read on accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (acc) begin
      rd_data_r <= line_mem[col];
    end
    if (s1_valid_r) begin
      line_mem[s1_col_r] <= wr_ent;
    end
  end

  // Take the entry just written when the read raced it
  assign rd_ent       = fwd_hit_r ? fwd_data_r : rd_data_r;
  assign wr_ent.older = rd_ent.prev;
  assign wr_ent.prev  = s1_pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      win_valid_r <= 1'b0;
      fwd_hit_r   <= 1'b0;
    end else begin
      s1_valid_r  <= acc;
      win_valid_r <= s1_valid_r;
      fwd_hit_r   <= acc && s1_valid_r && (col == s1_col_r);
    end
  end

  // Hold stage payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_col_r  <= col;
      s1_pix_r  <= pix;
      s1_ctrl_r <= ctrl_in;
    end
    fwd_data_r <= wr_ent;
    win_ctrl_r <= s1_ctrl_r;
  end

  // Advance the window one column
  always_ff @(posedge clk) begin
    if (s1_valid_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r][0] <= win_r[r][1];
        win_r[r][1] <= win_r[r][2];
      end
      win_r[0][2] <= rd_ent.older;
      win_r[1][2] <= rd_ent.prev;
      win_r[2][2] <= s1_pix_r;
    end
  end

  assign win_valid = win_valid_r;
  assign win       = win_r;
  assign win_ctrl  = win_ctrl_r;

endmodule

FILE: hw/rtl/bbe_avg.sv
// Masked neighbor sums and rounded mean by reciprocal multiply.
`timescale 1ns / 1ps
module bbe_avg
  import bbe_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_vld,
  input  win_t  win,
  input  ctrl_t ctrl_in,
  output logic  push,
  output res_t  res
);

  logic [2:0][2:0][CSUM_W-1:0] csum_nxt;
  logic [2:0][2:0][CSUM_W-1:0] csum_r;
  logic                        s3_valid_r;
  ctrl_t                       s3_ctrl_r;
  logic [2:0][TSUM_W-1:0]      tsum;
  logic [1:0]                  rows;
  logic [1:0]                  cols;
  logic [CNT_W-1:0]            cnt;
  logic [2:0][NUM_W-1:0]       num_r;
  logic [RECIP_W-1:0]          recip_r;
  logic                        s4_valid_r;
  logic                        s4_last_r;
  logic [2:0][PROD_W-1:0]      prod_r;
  logic                        s5_valid_r;
  logic                        s5_last_r;

  function automatic logic [CSUM_W-1:0] col_sum(input logic [7:0] top, input logic [7:0] mid,
                                                input logic [7:0] bot, input logic use_top,
                                                input logic use_bot);
    logic [CSUM_W-1:0] s;
    s = CSUM_W'(mid);
    if (use_top) s = s + CSUM_W'(top);
    if (use_bot) s = s + CSUM_W'(bot);
    return s;
  endfunction

  // Sum each window column over the rows inside the frame
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      csum_nxt[c][0] = col_sum(win[0][c].red, win[1][c].red, win[2][c].red,
                               ctrl_in.has_top, ctrl_in.has_bottom);
      csum_nxt[c][1] = col_sum(win[0][c].green, win[1][c].green, win[2][c].green,
                               ctrl_in.has_top, ctrl_in.has_bottom);
      csum_nxt[c][2] = col_sum(win[0][c].blue, win[1][c].blue, win[2][c].blue,
                               ctrl_in.has_top, ctrl_in.has_bottom);
    end
  end

  // Combine the columns inside the frame, form 2*sum + count
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      tsum[ch] = TSUM_W'(csum_r[1][ch]);
      if (s3_ctrl_r.has_left)  tsum[ch] = tsum[ch] + TSUM_W'(csum_r[0][ch]);
      if (s3_ctrl_r.has_right) tsum[ch] = tsum[ch] + TSUM_W'(csum_r[2][ch]);
    end
    rows = 2'd1 + 2'(s3_ctrl_r.has_top) + 2'(s3_ctrl_r.has_bottom);
    cols = 2'd1 + 2'(s3_ctrl_r.has_left) + 2'(s3_ctrl_r.has_right);
    cnt  = CNT_W'(rows) * CNT_W'(cols);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= in_vld;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    csum_r    <= csum_nxt;
    s3_ctrl_r <= ctrl_in;
    for (int ch = 0; ch < 3; ch++) begin
      num_r[ch]  <= {tsum[ch], 1'b0} + NUM_W'(cnt);
      prod_r[ch] <= PROD_W'(num_r[ch]) * PROD_W'(recip_r);
    end
    recip_r   <= recip(cnt);
    s4_last_r <= s3_ctrl_r.last;
    s5_last_r <= s4_last_r;
  end

  assign push            = s5_valid_r;
  assign res.color.red   = prod_r[0][RECIP_SHIFT +: 8];
  assign res.color.green = prod_r[1][RECIP_SHIFT +: 8];
  assign res.color.blue  = prod_r[2][RECIP_SHIFT +: 8];
  assign res.last        = s5_last_r;

endmodule

FILE: hw/rtl/bbe_out_fifo.sv
// Small output queue that decouples the pipeline from result back-pressure.
`timescale 1ns / 1ps
module bbe_out_fifo
  import bbe_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  res_t               push_data,
  output logic               out_vld,
  input  logic               out_rdy,
  output res_t               out_data,
  output logic [FIFO_CW-1:0] count
);

  res_t               fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_r;
  logic [FIFO_AW-1:0] rd_ptr_r;
  logic [FIFO_CW-1:0] cnt_r;
  logic [FIFO_CW-1:0] cnt_nxt;
  logic               pop;

  assign pop = out_vld && out_rdy;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  // Store pushed results
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  assign out_vld  = (cnt_r != '0);
  assign out_data = fifo_mem[rd_ptr_r];
  assign count    = cnt_r;

endmodule

FILE: hw/rtl/box_blur_3x3_edge_aware_unit.sv
// Streaming 3x3 box blur over RGB pixels with frame-edge aware averaging.
// The unit takes one request per clock while in_ready is high: pixels in
// raster order, then frame_width+1 drain requests after the last pixel of a
// frame. Each blurred pixel leaves frame_width+1 requests after its own pixel
// entered, and the last one of a frame carries frame_last. The result path
// is a registered read of the line buffer memory, a write-back with
// forwarding for back-to-back requests to the same column, the window
// register, two summing stages and a reciprocal multiply. An eight-entry
// output queue absorbs back-pressure; in_ready drops only when results in
// flight plus queued ones would fill it.
// Frame registers must be written between frames, with the unit idle.
`timescale 1ns / 1ps
module box_blur_3x3_edge_aware_unit
  import bbe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [7:0]           in_red_in,
  input  logic [7:0]           in_green_in,
  input  logic [7:0]           in_blue_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_red_out,
  output logic [7:0]           out_green_out,
  output logic [7:0]           out_blue_out,
  output logic                 out_frame_last
);

  logic [FW_W-1:0]    fw_r;
  logic [FH_W-1:0]    fh_r;
  logic [FW_W-1:0]    w_eff;
  logic [FH_W-1:0]    h_eff;
  logic [COL_W-1:0]   in_col_r;
  logic [COL_W-1:0]   in_col_nxt;
  logic [COL_W-1:0]   out_col_r;
  logic [COL_W-1:0]   out_col_nxt;
  logic [FH_W-1:0]    out_row_r;
  logic [FH_W-1:0]    out_row_nxt;
  logic [TAKEN_W-1:0] taken_r;
  logic [TAKEN_W-1:0] taken_nxt;
  logic [FW_W-1:0]    col_inc;
  logic [FW_W-1:0]    oc_inc;
  logic [FH_W:0]      or_inc;
  logic               acc;
  logic               acc_emit;
  ctrl_t              ctrl;
  pix_t               pix;
  logic [FIFO_CW-1:0] inflight_r;
  logic [FIFO_CW-1:0] inflight_nxt;
  logic [FIFO_CW:0]   credit_used;
  logic               win_valid;
  win_t               win;
  ctrl_t              win_ctrl;
  logic               push;
  res_t               push_data;
  res_t               out_data;
  logic [FIFO_CW-1:0] fifo_cnt;

  // Frame registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  fw_r <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_r <= cfg_wdata[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size into the supported range
  always_comb begin
    if (fw_r == '0) w_eff = FW_W'(1);
    else if (fw_r > FW_W'(MAX_WIDTH)) w_eff = FW_W'(MAX_WIDTH);
    else w_eff = fw_r;
    h_eff = (fh_r == '0) ? FH_W'(1) : fh_r;
  end

  assign acc      = in_valid && in_ready;
  assign acc_emit = acc && ctrl.emit;
  assign pix      = (in_cmd == CMD_PIXEL) ? {in_red_in, in_green_in, in_blue_in} : '0;

  // Classify the request: does it release a result, and where does that pixel sit
  always_comb begin
    col_inc         = FW_W'(in_col_r) + 1'b1;
    oc_inc          = FW_W'(out_col_r) + 1'b1;
    or_inc          = (FH_W+1)'(out_row_r) + 1'b1;
    ctrl.emit       = (TAKEN_W+1)'(taken_r) >= (TAKEN_W+1)'(w_eff) + 1'b1;
    ctrl.has_left   = (out_col_r != '0);
    ctrl.has_right  = (oc_inc < w_eff);
    ctrl.has_top    = (out_row_r != '0);
    ctrl.has_bottom = (or_inc < (FH_W+1)'(h_eff));
    ctrl.last       = ctrl.emit && !ctrl.has_right && !ctrl.has_bottom;
  end

  // Next counter values
  always_comb begin
    in_col_nxt  = (col_inc >= w_eff) ? '0 : col_inc[COL_W-1:0];
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    taken_nxt   = taken_r;
    if (!ctrl.emit) begin
      taken_nxt = taken_r + 1'b1;
    end else if (ctrl.last) begin
      in_col_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
      taken_nxt   = '0;
    end else if (!ctrl.has_right) begin
      out_col_nxt = '0;
      out_row_nxt = or_inc[FH_W-1:0];
    end else begin
      out_col_nxt = oc_inc[COL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      taken_r   <= '0;
    end else if (acc) begin
      in_col_r  <= in_col_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      taken_r   <= taken_nxt;
    end
  end

  // Track results in flight so the queue can never overflow
  always_comb begin
    inflight_nxt = inflight_r;
    if (acc_emit && !push) inflight_nxt = inflight_r + 1'b1;
    if (push && !acc_emit) inflight_nxt = inflight_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_nxt;
    end
  end

  assign credit_used = (FIFO_CW+1)'(fifo_cnt) + (FIFO_CW+1)'(inflight_r);
  assign in_ready    = credit_used < (FIFO_CW+1)'(FIFO_DEPTH);

  bbe_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .col       (in_col_r),
    .pix       (pix),
    .ctrl_in   (ctrl),
    .win_valid (win_valid),
    .win       (win),
    .win_ctrl  (win_ctrl)
  );

  bbe_avg u_avg (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (win_valid && win_ctrl.emit),
    .win     (win),
    .ctrl_in (win_ctrl),
    .push    (push),
    .res     (push_data)
  );

  bbe_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_vld   (out_valid),
    .out_rdy   (out_ready),
    .out_data  (out_data),
    .count     (fifo_cnt)
  );

  assign out_red_out    = out_data.color.red;
  assign out_green_out  = out_data.color.green;
  assign out_blue_out   = out_data.color.blue;
  assign out_frame_last = out_data.last;

  // Queue plus in-flight results never exceed the queue depth
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_used <= (FIFO_CW+1)'(FIFO_DEPTH))
    else $error("output queue credit exceeded");

  // Every releasing request is followed by its push into the output queue
  a_push_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc_emit |-> ##5 push)
    else $error("result did not reach the output queue in time");

  // The final pixel of a frame returns all counters to the frame start
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && ctrl.last) |=> (in_col_r == '0 && out_col_r == '0 &&
                            out_row_r == '0 && taken_r == '0))
    else $error("counters not cleared after frame end");

endmodule

FILE: dv/tb_box_blur_3x3_edge_aware_unit.sv
// Self-checking testbench for the streaming 3x3 edge-aware box blur unit.
`timescale 1ns / 1ps
module tb_box_blur_3x3_edge_aware_unit;
  import bbe_pkg::*;

  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int RANDOM_ITEMS = 500;
  localparam int SETTLE       = 12;   // lets the result path empty
  localparam int REPORT_CAP   = 100;

  typedef enum logic {ROW_REGS, ROW_REQ} row_kind_e;
  typedef enum int {RX_OPEN, RX_BUSY, RX_LIGHT, RX_BEAT, RX_STALL} rx_mode_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CFG_W-1:0] wval;
    logic [CFG_W-1:0] hval;
    logic             cmd;
    logic [23:0]      rgb;
    logic             typed;
    logic [23:0]      want_rgb;
    logic             want_last;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_PIXEL;
  logic [7:0]           in_red_in = '0;
  logic [7:0]           in_green_in = '0;
  logic [7:0]           in_blue_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_red_out;
  logic [7:0]           out_green_out;
  logic [7:0]           out_blue_out;
  logic                 out_frame_last;

  box_blur_3x3_edge_aware_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_frame_last(out_frame_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Blur predictor state: frame registers, two line stores, window, counters
  logic [FW_W-1:0]    width_reg = FW_RESET;
  logic [FH_W-1:0]    height_reg = FH_RESET;
  pix_t               line_prev [MAX_WIDTH] = '{default: '0};
  pix_t               line_older [MAX_WIDTH] = '{default: '0};
  pix_t               win [3][3] = '{default: '0};
  logic [COL_W-1:0]   in_col = '0;
  logic [COL_W-1:0]   out_col = '0;
  logic [FH_W-1:0]    out_row = '0;
  logic [TAKEN_W-1:0] fill_count = '0;

  res_t blurred_q [$];
  int   bad_results = 0;
  bit   req_held = 1'b0;
  int   burst_left = 0;

  // One short frame per corner case; expectations typed only
  // where the blurred pixel is the lone pixel of a 1x1 frame
  dir_row_t directed [32] = '{
    // zero registers act as a 1x1 frame
    '{ROW_REGS, 16'h0000, 16'h0000, CMD_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b1, 24'hFFFFFF, 1'b1},
    // pixels sent while the drain is due count as drains
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'hAA55AA, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'h55AA55, 1'b1, 24'h000000, 1'b1},
    // a drain inside the frame is a black pixel
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h123456, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'h808080, 1'b1, 24'h000000, 1'b1},
    // 2x2 frame, width upper bits set and ignored
    '{ROW_REGS, 16'hF802, 16'h0002, CMD_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'hFF0080, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'h01FE7F, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0},
    // one-row frame
    '{ROW_REGS, 16'h0003, 16'h0001, CMD_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'h102030, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'hFFFFFF, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'h000102, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0},
    // one-column frame
    '{ROW_REGS, 16'h0001, 16'h0003, CMD_PIXEL, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'hFE017F, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'h01FE80, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_PIXEL, 24'hFFFF00, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0},
    '{ROW_REQ,  16'h0000, 16'h0000, CMD_DRAIN, 24'h000000, 1'b0, 24'h000000, 1'b0}
  };

  function automatic int active_width();
    if (width_reg == '0) return 1;
    if (width_reg > MAX_WIDTH) return MAX_WIDTH;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    return (height_reg == '0) ? 1 : int'(height_reg);
  endfunction

  // Advance the blur predictor by one accepted request
  task automatic blur_step(input logic cmd, input pix_t px, output bit emitted,
                           output res_t blurred);
    int   w, h, col, n;
    int   sum_r, sum_g, sum_b;
    bit   left_in, right_in, top_in, bottom_in;
    pix_t p;
    w = active_width();
    h = active_height();
    p = (cmd == CMD_PIXEL) ? px : '0;
    col = int'(in_col);
    // shift the window left and load the new column from the line stores
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_older[col];
    win[1][2] = line_prev[col];
    win[2][2] = p;
    line_older[col] = line_prev[col];
    line_prev[col] = p;
    if (col + 1 >= w) in_col = '0;
    else in_col = COL_W'(col + 1);

    emitted = 1'b0;
    blurred = '0;
    if (fill_count < w + 1) begin
      fill_count = fill_count + 1'b1;
    end else begin
      left_in   = out_col > 0;
      right_in  = out_col + 1 < w;
      top_in    = out_row > 0;
      bottom_in = out_row + 1 < h;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      n = 0;
      // sum only the neighbors that lie inside the frame
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if ((r != 0 || top_in) && (r != 2 || bottom_in) &&
              (c != 0 || left_in) && (c != 2 || right_in)) begin
            sum_r = sum_r + win[r][c].red;
            sum_g = sum_g + win[r][c].green;
            sum_b = sum_b + win[r][c].blue;
            n++;
          end
        end
      end
      emitted = 1'b1;
      blurred.color.red   = 8'((2 * sum_r + n) / (2 * n));
      blurred.color.green = 8'((2 * sum_g + n) / (2 * n));
      blurred.color.blue  = 8'((2 * sum_b + n) / (2 * n));
      blurred.last = (out_col + 1 >= w) && (out_row + 1 >= h);
      // restart counters at frame end, else advance the output position
      if (blurred.last) begin
        in_col = '0;
        out_col = '0;
        out_row = '0;
        fill_count = '0;
      end else if (out_col + 1 >= w) begin
        out_col = '0;
        out_row = out_row + 1'b1;
      end else begin
        out_col = out_col + 1'b1;
      end
    end
  endtask

  // Present one request, hold it until taken, then pace the sender
  task automatic push_request(input logic cmd, input pix_t px, input bit typed,
                              input res_t want);
    bit   emitted;
    res_t blurred;
    in_cmd      <= cmd;
    in_red_in   <= px.red;
    in_green_in <= px.green;
    in_blue_in  <= px.blue;
    in_valid    <= 1'b1;
    req_held = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    blur_step(cmd, px, emitted, blurred);
    if (emitted) blurred_q.push_back(typed ? want : blurred);
    // bursts of random length, random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      req_held = 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20);
    end
  endtask

  // Hold off requests until every blurred pixel has come out
  task automatic pause_until_drained();
    if (req_held) begin
      in_valid <= 1'b0;
      req_held = 1'b0;
    end
    while (blurred_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_frame(input logic [CFG_W-1:0] wval, input logic [CFG_W-1:0] hval);
    pause_until_drained();
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= wval;
    @(posedge clk);
    width_reg = wval[FW_W-1:0];
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= hval;
    @(posedge clk);
    height_reg = hval[FH_W-1:0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] rand_level();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One whole frame plus its drain, mostly well formed with some noise
  task automatic run_frame(input logic [CFG_W-1:0] wval, input logic [CFG_W-1:0] hval,
                           output int sent);
    int   w, total;
    logic cmd;
    pix_t px;
    write_frame(wval, hval);
    w = active_width();
    total = w * active_height() + w + 1;
    for (int k = 0; k < total; k++) begin
      if (k < total - w - 1) cmd = ($urandom_range(0, 19) == 0) ? CMD_DRAIN : CMD_PIXEL;
      else cmd = ($urandom_range(0, 9) == 0) ? CMD_PIXEL : CMD_DRAIN;
      px.red   = rand_level();
      px.green = rand_level();
      px.blue  = rand_level();
      if ($urandom_range(0, 199) == 0) pause_until_drained();
      push_request(cmd, px, 1'b0, '0);
    end
    sent = total;
  endtask

  // Receiver stalls: a randomly chosen mode of out_ready pacing
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_left = 0;
  int       rx_tick = 0;

  always @(posedge clk) begin
    rx_tick++;
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 4));
      rx_left = $urandom_range(50, 400);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_BUSY:  out_ready <= ($urandom_range(0, 9) < 3);
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_BEAT:  out_ready <= (rx_tick % 4 == 0);
      default:  out_ready <= (rx_tick % 40 >= 16);
    endcase
  end

  // Compare each taken result with the oldest blurred pixel due
  always @(posedge clk) begin : check_out
    res_t due;
    if (rst_n && out_valid && out_ready) begin
      if (blurred_q.size() == 0) begin
        bad_results++;
        if (bad_results <= REPORT_CAP) $error("result taken with no blurred pixel due");
      end else begin
        due = blurred_q.pop_front();
        if (out_red_out !== due.color.red) begin
          bad_results++;
          if (bad_results <= REPORT_CAP)
            $error("red_out: expected %0d, got %0d", due.color.red, out_red_out);
        end
        if (out_green_out !== due.color.green) begin
          bad_results++;
          if (bad_results <= REPORT_CAP)
            $error("green_out: expected %0d, got %0d", due.color.green, out_green_out);
        end
        if (out_blue_out !== due.color.blue) begin
          bad_results++;
          if (bad_results <= REPORT_CAP)
            $error("blue_out: expected %0d, got %0d", due.color.blue, out_blue_out);
        end
        if (out_frame_last !== due.last) begin
          bad_results++;
          if (bad_results <= REPORT_CAP)
            $error("frame_last: expected %0d, got %0d", due.last, out_frame_last);
        end
      end
    end
  end

  // Watchdog
  int unsigned cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int              sent, n, pick;
    logic [FW_W-1:0] w_pick;
    logic [FH_W-1:0] h_pick;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // walk the directed table
    foreach (directed[i]) begin
      if (directed[i].kind == ROW_REGS)
        write_frame(directed[i].wval, directed[i].hval);
      else
        push_request(directed[i].cmd, directed[i].rgb, directed[i].typed,
                     {directed[i].want_rgb, directed[i].want_last});
    end

    // widest frame: width register above the maximum
    run_frame(16'h07FF, 16'h0001, n);

    // random frames, mostly small
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        w_pick = FW_W'($urandom_range(1, 8));
        h_pick = FH_W'($urandom_range(1, 6));
      end else if (pick <= 7) begin
        w_pick = FW_W'($urandom_range(9, 40));
        h_pick = FH_W'($urandom_range(1, 3));
      end else if (pick == 8) begin
        w_pick = '0;
        h_pick = FH_W'($urandom_range(0, 4));
      end else begin
        w_pick = FW_W'($urandom_range(1, 16));
        h_pick = '0;
      end
      run_frame({5'($urandom_range(0, 31)), w_pick}, h_pick, n);
      sent += n;
    end

    pause_until_drained();
    if (bad_results == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
